### design/gsts_pkg.sv
`default_nettype none

package gsts_pkg;

  // Item fields
  localparam int KEY_W    = 31;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;

  // Stored word: valid mark above the key
  localparam int WORD_W = KEY_W + 1;

  // Expansion factor register
  localparam int                EF_W     = 4;
  localparam logic [EF_W-1:0]   EF_MIN   = 4'd1;
  localparam logic [EF_W-1:0]   EF_MAX   = 4'd8;
  localparam logic [EF_W-1:0]   EF_RESET = 4'd2;

  // APB port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_EXPANSION_FACTOR = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_KEY   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_APP_INIT,
    OP_APP_WR,
    OP_PROBE_INIT,
    OP_PROBE_RD,
    OP_PROBE_STEP,
    OP_BACK,
    OP_BS_RD,
    OP_BS_STEP,
    OP_REM_WR
  } dp_op_e;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_MID,
    POS_BASE
  } pos_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     res_we;
    logic     res_found;
    status_e  res_status;
    pos_sel_e res_pos;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  key_zero;
    logic  app_bad;
    logic  app_full;
    logic  app_last;
    logic  probe_can;
    logic  probe_go;
    logic  bs_hit;
    logic  bs_end;
    logic  res_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/gapped_sorted_table_search_core.sv
`default_nettype none
// Gapped sorted key table with exponential-then-binary search.
// Input channel (in_valid_i / in_stall_o) carries mode_i and key_i: clear,
// append, search or remove. One result per item on the output channel
// (out_valid_o / out_stall_i): found_o, position_o, status_o.
// Items are worked one at a time; a result sits in the output register while
// the next item is taken in and processed.
// Work per item, from transfer in to result registered:
//   clear   fill count reset only
//   append  one memory write per slot, expansion factor slots
//   search  P probe reads (at most log2(TABLE_DEPTH)) and B bisection
//           steps (at most log2(TABLE_DEPTH)+1), each a read of the key
//           memory plus a compare
//   remove  as search plus one memory write
// Rejected and bad-key items go straight to the result. The next item is
// taken the cycle after the result is registered.
// If out_stall_i holds, a finished item waits in its last state until the
// output register frees. Reset empties the table at once (the fill count
// governs which slots read as occupied), so no clearing pass follows reset.
// expansion_factor (APB, address 0) may be rewritten only while idle.

module gapped_sorted_table_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gsts_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [gsts_pkg::KEY_W-1:0]    key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic [gsts_pkg::POS_W-1:0]         position_o,
  output logic [gsts_pkg::STATUS_W-1:0]      status_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gsts_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gsts_pkg::DATA_W-1:0]   pwdata,
  output logic [gsts_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [gsts_pkg::EF_W-1:0]      ef_q;
  logic [gsts_pkg::REG_IDX_W-1:0] reg_idx;
  gsts_pkg::dp_cmd_t              cmd;
  gsts_pkg::dp_sts_t              sts;
  logic                           idle;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gsts_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ef_q <= gsts_pkg::EF_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == gsts_pkg::REG_EXPANSION_FACTOR)) begin
      ef_q <= pwdata[gsts_pkg::EF_W-1:0];
    end
  end

  assign prdata = (reg_idx == gsts_pkg::REG_EXPANSION_FACTOR) ?
                  gsts_pkg::DATA_W'(ef_q) : '0;

  assign in_stall_o = !idle;

  gsts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  gsts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .ef_i        (ef_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .position_o  (position_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### design/gsts_ctrl.sv
`default_nettype none

module gsts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire gsts_pkg::dp_sts_t sts_i,
  output gsts_pkg::dp_cmd_t      cmd_o,
  output logic                   idle_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_WR,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_BACK,
    S_BS_RD,
    S_BS_CMP,
    S_REM_WR,
    S_FINISH
  } state_e;

  state_e             state_q, state_d;
  logic               fin_found_q, fin_found_d;
  gsts_pkg::status_e  fin_status_q, fin_status_d;
  gsts_pkg::pos_sel_e fin_pos_q, fin_pos_d;

  always_comb begin
    state_d      = state_q;
    fin_found_d  = fin_found_q;
    fin_status_d = fin_status_q;
    fin_pos_d    = fin_pos_q;
    cmd_o            = '0;
    cmd_o.op         = gsts_pkg::OP_NONE;
    cmd_o.res_found  = fin_found_q;
    cmd_o.res_status = fin_status_q;
    cmd_o.res_pos    = fin_pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gsts_pkg::OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        fin_found_d  = 1'b0;
        fin_status_d = gsts_pkg::ST_DONE;
        fin_pos_d    = gsts_pkg::POS_ZERO;
        unique case (sts_i.mode)
          gsts_pkg::MODE_CLEAR: begin
            cmd_o.op = gsts_pkg::OP_CLEAR;
            state_d  = S_FINISH;
          end
          gsts_pkg::MODE_APPEND: begin
            priority if (sts_i.app_bad) begin
              fin_status_d = gsts_pkg::ST_BAD_KEY;
              state_d      = S_FINISH;
            end else if (sts_i.app_full) begin
              fin_status_d = gsts_pkg::ST_FULL;
              state_d      = S_FINISH;
            end else begin
              cmd_o.op  = gsts_pkg::OP_APP_INIT;
              fin_pos_d = gsts_pkg::POS_BASE;
              state_d   = S_APP_WR;
            end
          end
          gsts_pkg::MODE_SEARCH, gsts_pkg::MODE_REMOVE: begin
            if (sts_i.key_zero) begin
              fin_status_d = gsts_pkg::ST_BAD_KEY;
              state_d      = S_FINISH;
            end else begin
              cmd_o.op = gsts_pkg::OP_PROBE_INIT;
              state_d  = S_PROBE_RD;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_APP_WR: begin
        cmd_o.op = gsts_pkg::OP_APP_WR;
        if (sts_i.app_last) begin
          state_d = S_FINISH;
        end
      end
      S_PROBE_RD: begin
        // past the filled part every slot is empty, so probing stops there
        if (sts_i.probe_can) begin
          cmd_o.op = gsts_pkg::OP_PROBE_RD;
          state_d  = S_PROBE_CMP;
        end else begin
          state_d = S_BACK;
        end
      end
      S_PROBE_CMP: begin
        if (sts_i.probe_go) begin
          cmd_o.op = gsts_pkg::OP_PROBE_STEP;
          state_d  = S_PROBE_RD;
        end else begin
          state_d = S_BACK;
        end
      end
      S_BACK: begin
        cmd_o.op = gsts_pkg::OP_BACK;
        state_d  = S_BS_RD;
      end
      S_BS_RD: begin
        cmd_o.op = gsts_pkg::OP_BS_RD;
        state_d  = S_BS_CMP;
      end
      S_BS_CMP: begin
        priority if (sts_i.bs_hit) begin
          fin_found_d = 1'b1;
          fin_pos_d   = gsts_pkg::POS_MID;
          state_d     = (sts_i.mode == gsts_pkg::MODE_REMOVE) ? S_REM_WR : S_FINISH;
        end else if (sts_i.bs_end) begin
          fin_status_d = gsts_pkg::ST_NOT_FOUND;
          state_d      = S_FINISH;
        end else begin
          cmd_o.op = gsts_pkg::OP_BS_STEP;
          state_d  = S_BS_RD;
        end
      end
      S_REM_WR: begin
        cmd_o.op = gsts_pkg::OP_REM_WR;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.res_busy) begin
          cmd_o.res_we = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fin_found_q  <= 1'b0;
      fin_status_q <= gsts_pkg::ST_DONE;
      fin_pos_q    <= gsts_pkg::POS_ZERO;
    end else begin
      state_q      <= state_d;
      fin_found_q  <= fin_found_d;
      fin_status_q <= fin_status_d;
      fin_pos_q    <= fin_pos_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

### design/gsts_dpath.sv
`default_nettype none

module gsts_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [gsts_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [gsts_pkg::KEY_W-1:0]    key_i,
  input  wire logic [gsts_pkg::EF_W-1:0]     ef_i,
  input  wire gsts_pkg::dp_cmd_t             cmd_i,
  output gsts_pkg::dp_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic [gsts_pkg::POS_W-1:0]         position_o,
  output logic [gsts_pkg::STATUS_W-1:0]      status_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST  = CW'(TABLE_DEPTH - 1);
  localparam logic [CW:0]   DEPTH = (CW+1)'(TABLE_DEPTH);

  logic [gsts_pkg::WORD_W-1:0] mem [TABLE_DEPTH];

  gsts_pkg::mode_e              mode_q;
  logic [gsts_pkg::KEY_W-1:0]   key_q;
  logic [gsts_pkg::KEY_W-1:0]   last_q;
  logic [CW-1:0]                cnt_q;
  logic [AW-1:0]                hi_q, lo_q, mid_q, base_q, wr_ptr_q;
  logic [gsts_pkg::EF_W-1:0]    left_q;
  logic [gsts_pkg::WORD_W-1:0]  rd_q;
  logic                         rd_live_q;
  logic                         res_valid_q;
  logic                         found_q;
  logic [gsts_pkg::POS_W-1:0]   pos_q;
  gsts_pkg::status_e            status_q;

  logic [gsts_pkg::EF_W-1:0]    eff;
  logic [gsts_pkg::KEY_W-1:0]   rd_key;
  logic                         rd_vld;
  logic                         go_left;
  logic [CW-1:0]                dbl;
  logic [CW-1:0]                cnt_m1;
  logic [CW:0]                  fill_sum;
  logic [CW-1:0]                mid_sum;
  logic [AW-1:0]                mid_c;
  logic [AW-1:0]                rd_addr;
  logic                         mem_we;
  logic [AW-1:0]                wr_addr;
  logic [gsts_pkg::WORD_W-1:0]  wr_data;
  logic [AW-1:0]                pos_idx;
  logic [AW+gsts_pkg::POS_W-1:0] pos_ext;

  always_comb begin
    priority if (ef_i < gsts_pkg::EF_MIN) begin
      eff = gsts_pkg::EF_MIN;
    end else if (ef_i > gsts_pkg::EF_MAX) begin
      eff = gsts_pkg::EF_MAX;
    end else begin
      eff = ef_i;
    end
  end

  // Slots at or beyond the fill count are empty whatever the memory holds
  assign rd_key   = rd_live_q ? rd_q[gsts_pkg::KEY_W-1:0] : '0;
  assign rd_vld   = rd_live_q & rd_q[gsts_pkg::KEY_W];
  assign go_left  = (rd_key >= key_q);
  assign dbl      = {hi_q, 1'b0};
  assign cnt_m1   = cnt_q - CW'(1);
  assign fill_sum = {1'b0, cnt_q} + (CW+1)'(eff);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c    = mid_sum[AW:1];

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.key_zero  = (key_q == '0);
    sts_o.app_bad   = (key_q == '0) || (key_q <= last_q);
    sts_o.app_full  = (fill_sum > DEPTH);
    sts_o.app_last  = (left_q == gsts_pkg::EF_W'(1));
    sts_o.probe_can = ({1'b0, hi_q} < LAST) && ({1'b0, hi_q} < cnt_q);
    sts_o.probe_go  = (key_q > rd_key);
    sts_o.bs_hit    = (rd_key == key_q) && rd_vld;
    sts_o.bs_end    = go_left ? (mid_q == lo_q) : (mid_q == hi_q);
    sts_o.res_busy  = res_valid_q && out_stall_i;
  end

  always_comb begin
    rd_addr = (cmd_i.op == gsts_pkg::OP_BS_RD) ? mid_c : hi_q;
    mem_we  = 1'b0;
    wr_addr = wr_ptr_q;
    wr_data = {(wr_ptr_q == base_q), key_q};
    if (cmd_i.op == gsts_pkg::OP_APP_WR) begin
      mem_we = 1'b1;
    end else if (cmd_i.op == gsts_pkg::OP_REM_WR) begin
      mem_we  = 1'b1;
      wr_addr = mid_q;
      wr_data = {1'b0, key_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q      <= mem[rd_addr];
    rd_live_q <= ({1'b0, rd_addr} < cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      unique case (cmd_i.op)
        gsts_pkg::OP_CLEAR: begin
          cnt_q  <= '0;
          last_q <= '0;
        end
        gsts_pkg::OP_APP_INIT: begin
          cnt_q  <= fill_sum[CW-1:0];
          last_q <= key_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      gsts_pkg::OP_LOAD: begin
        mode_q <= gsts_pkg::mode_e'(mode_i);
        key_q  <= key_i;
      end
      gsts_pkg::OP_APP_INIT: begin
        base_q   <= cnt_q[AW-1:0];
        wr_ptr_q <= cnt_q[AW-1:0];
        left_q   <= eff;
      end
      gsts_pkg::OP_APP_WR: begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
        left_q   <= left_q - gsts_pkg::EF_W'(1);
      end
      gsts_pkg::OP_PROBE_INIT: begin
        hi_q <= AW'(1);
      end
      gsts_pkg::OP_PROBE_STEP: begin
        hi_q <= (dbl > LAST) ? LAST[AW-1:0] : dbl[AW-1:0];
      end
      gsts_pkg::OP_BACK: begin
        // step back over empty slots: land on the last filled one
        lo_q <= '0;
        if ({1'b0, hi_q} >= cnt_q) begin
          hi_q <= (cnt_q == '0) ? '0 : cnt_m1[AW-1:0];
        end
      end
      gsts_pkg::OP_BS_RD: begin
        mid_q <= mid_c;
      end
      gsts_pkg::OP_BS_STEP: begin
        if (go_left) begin
          hi_q <= mid_q - AW'(1);
        end else begin
          lo_q <= mid_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd_i.res_pos)
      gsts_pkg::POS_MID:  pos_idx = mid_q;
      gsts_pkg::POS_BASE: pos_idx = base_q;
      default:            pos_idx = '0;
    endcase
    pos_ext = {{gsts_pkg::POS_W{1'b0}}, pos_idx};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_we) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      found_q  <= cmd_i.res_found;
      pos_q    <= pos_ext[gsts_pkg::POS_W-1:0];
      status_q <= cmd_i.res_status;
    end
  end

  assign out_valid_o = res_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### design/gsts_chk.sv
`default_nettype none

module gsts_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          found_o,
  input wire logic [gsts_pkg::POS_W-1:0]    position_o,
  input wire logic [gsts_pkg::STATUS_W-1:0] status_o,
  input wire logic                          pready
);

  // A result held under stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One item in flight: a transfer in closes the input for the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in progress");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == gsts_pkg::ST_DONE)
    else $error("found with a failing status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gsts_pkg::ST_DONE |-> !found_o && position_o == '0)
    else $error("failed item carries a position");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port not ready");

endmodule

bind gapped_sorted_table_search_core gsts_chk u_gsts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .position_o  (position_o),
  .status_o    (status_o),
  .pready      (pready)
);

`default_nettype wire
